### src/ppm_pkg.sv
package ppm_pkg;

  // Sample and register widths
  localparam int unsigned ADC_BITS = 12;
  localparam int unsigned ADC_W    = ADC_BITS;
  localparam int unsigned TIME_W   = 32;

  // Scaled pedal position
  localparam int unsigned SCALE_W    = 15;
  localparam int unsigned NUM_W      = ADC_W + SCALE_W;
  localparam int unsigned CNT_W      = $clog2(SCALE_W);
  localparam logic [SCALE_W-1:0] FULL_SCALE        = SCALE_W'(32767);
  localparam logic [SCALE_W-1:0] LATCH_SET_LEVEL   = SCALE_W'(8191);
  localparam logic [SCALE_W-1:0] LATCH_CLEAR_LEVEL = SCALE_W'(1638);

  // Disagreement must persist this long before it is a fault
  localparam int unsigned DISAGREE_TIME_MS = 100;

  // Configuration registers
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = $clog2(NUM_REGS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_APPS1_MIN        = 3'd0,
    CFG_APPS1_SPAN       = 3'd1,
    CFG_APPS2_MAX        = 3'd2,
    CFG_APPS2_SPAN       = 3'd3,
    CFG_FRONT_BRAKE_MIN  = 3'd4,
    CFG_REAR_BRAKE_MIN   = 3'd5,
    CFG_BRAKE_FAULT_LOW  = 3'd6,
    CFG_BRAKE_FAULT_HIGH = 3'd7
  } cfg_idx_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // take in a sample set
    logic load;     // prepare a division
    logic sel;      // 0: pedal one, 1: pedal two
    logic step;     // one quotient bit
    logic commit;   // evaluate faults, write result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;  // current step produces the final quotient bit
  } sts_t;

  // One result item
  typedef struct packed {
    logic [SCALE_W-1:0] apps1_scaled;
    logic [SCALE_W-1:0] apps2_scaled;
    logic               brake_sensor_fault;
    logic               apps_disagree_fault;
    logic               brake_throttle_fault;
    logic               any_fault;
  } res_t;

endpackage

### src/ppm_in_if.sv
interface ppm_in_if;
  logic                      valid;
  logic                      ready;
  logic [ppm_pkg::ADC_W-1:0]  pedal1_adc;
  logic [ppm_pkg::ADC_W-1:0]  pedal2_adc;
  logic [ppm_pkg::ADC_W-1:0]  front_press_adc;
  logic [ppm_pkg::ADC_W-1:0]  rear_press_adc;
  logic [ppm_pkg::TIME_W-1:0] now_ms;

  modport source (
    output valid, pedal1_adc, pedal2_adc, front_press_adc, rear_press_adc, now_ms,
    input  ready
  );
  modport sink (
    input  valid, pedal1_adc, pedal2_adc, front_press_adc, rear_press_adc, now_ms,
    output ready
  );
endinterface

### src/ppm_out_if.sv
interface ppm_out_if;
  logic                        valid;
  logic                        ready;
  logic [ppm_pkg::SCALE_W-1:0] apps1_scaled;
  logic [ppm_pkg::SCALE_W-1:0] apps2_scaled;
  logic                        brake_sensor_fault;
  logic                        apps_disagree_fault;
  logic                        brake_throttle_fault;
  logic                        any_fault;

  modport source (
    output valid, apps1_scaled, apps2_scaled, brake_sensor_fault,
           apps_disagree_fault, brake_throttle_fault, any_fault,
    input  ready
  );
  modport sink (
    input  valid, apps1_scaled, apps2_scaled, brake_sensor_fault,
           apps_disagree_fault, brake_throttle_fault, any_fault,
    output ready
  );
endinterface

### src/pedal_plausibility_monitor.sv
// Pedal plausibility monitor. Each transfer on in_i carries one sample set (two
// accelerator pedal readings, two brake readings, a millisecond timestamp); each
// produces exactly one result on out_o with both pedal positions scaled to
// 0..32767 and the brake sensor, pedal disagreement and brake-plus-throttle
// fault flags. Both scalings share one restoring divider that yields one
// quotient bit per cycle, and samples are handled one at a time: the next
// sample is accepted in the cycle after the previous result is written to
// the result register, even if that result has not yet been taken.
// A finished result waits in its register while the next sample is being
// worked on only once; a second result holds until the first is taken.
// The user must write configuration through cfg_we_i/cfg_idx_i/cfg_data_i
// only while the block is idle; the block itself does not enforce it.
module pedal_plausibility_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppm_pkg::ADC_W-1:0]     cfg_data_i,
  ppm_in_if.sink                        in_i,
  ppm_out_if.source                     out_o
);

  ppm_pkg::cmd_t cmd;
  ppm_pkg::sts_t sts;
  ppm_pkg::res_t res;

  ppm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppm_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .pedal1_adc_i      (in_i.pedal1_adc),
    .pedal2_adc_i      (in_i.pedal2_adc),
    .front_press_adc_i (in_i.front_press_adc),
    .rear_press_adc_i  (in_i.rear_press_adc),
    .now_ms_i          (in_i.now_ms),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .res_o             (res)
  );

  // Drive the result channel
  assign out_o.apps1_scaled         = res.apps1_scaled;
  assign out_o.apps2_scaled         = res.apps2_scaled;
  assign out_o.brake_sensor_fault   = res.brake_sensor_fault;
  assign out_o.apps_disagree_fault  = res.apps_disagree_fault;
  assign out_o.brake_throttle_fault = res.brake_throttle_fault;
  assign out_o.any_fault            = res.any_fault;

endmodule

### src/ppm_ctrl.sv
module ppm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ppm_pkg::sts_t sts_i,
  output ppm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD1,
    S_DIV1,
    S_LOAD2,
    S_DIV2,
    S_DONE
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Decode commands from the current state
  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i && in_ready_q;
    cmd_o.load    = (state_q == S_LOAD1) || (state_q == S_LOAD2);
    cmd_o.sel     = (state_q == S_LOAD2);
    cmd_o.step    = (state_q == S_DIV1) || (state_q == S_DIV2);
    cmd_o.commit  = (state_q == S_DONE) && out_free;
  end

  // Sequence one sample set through both divisions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_LOAD1;
            in_ready_q <= 1'b0;
          end else begin
            in_ready_q <= 1'b1;
          end
        end
        S_LOAD1: state_q <= S_DIV1;
        S_DIV1: begin
          if (sts_i.div_last) state_q <= S_LOAD2;
        end
        S_LOAD2: state_q <= S_DIV2;
        S_DIV2: begin
          if (sts_i.div_last) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Hold the result until the transfer completes
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

### src/ppm_datapath.sv
module ppm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppm_pkg::ADC_W-1:0]     cfg_data_i,
  input  logic [ppm_pkg::ADC_W-1:0]     pedal1_adc_i,
  input  logic [ppm_pkg::ADC_W-1:0]     pedal2_adc_i,
  input  logic [ppm_pkg::ADC_W-1:0]     front_press_adc_i,
  input  logic [ppm_pkg::ADC_W-1:0]     rear_press_adc_i,
  input  logic [ppm_pkg::TIME_W-1:0]    now_ms_i,
  input  ppm_pkg::cmd_t                 cmd_i,
  output ppm_pkg::sts_t                 sts_o,
  output ppm_pkg::res_t                 res_o
);

  localparam int unsigned AW = ppm_pkg::ADC_W;
  localparam int unsigned SW = ppm_pkg::SCALE_W;
  localparam int unsigned NW = ppm_pkg::NUM_W;
  localparam int unsigned TW = ppm_pkg::TIME_W;
  localparam int unsigned CW = ppm_pkg::CNT_W;
  localparam int unsigned DW = SW + 4;

  logic [AW-1:0] cfg_q [ppm_pkg::NUM_REGS];

  logic [AW-1:0] raw1_q, raw2_q, front_q, rear_q;
  logic [TW-1:0] now_q;

  logic [AW-1:0] rem_q, rem_d;
  logic [SW-1:0] lo_q;
  logic [SW-1:0] quo_q;
  logic [AW-1:0] span_q;
  logic          sat_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] s1_q;

  logic          dis_act_q;
  logic [TW-1:0] dis_start_q;
  logic          latch_q;

  ppm_pkg::res_t res_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[ppm_pkg::CFG_APPS1_MIN]        <= '0;
      cfg_q[ppm_pkg::CFG_APPS1_SPAN]       <= '1;
      cfg_q[ppm_pkg::CFG_APPS2_MAX]        <= '1;
      cfg_q[ppm_pkg::CFG_APPS2_SPAN]       <= '1;
      cfg_q[ppm_pkg::CFG_FRONT_BRAKE_MIN]  <= '0;
      cfg_q[ppm_pkg::CFG_REAR_BRAKE_MIN]   <= '0;
      cfg_q[ppm_pkg::CFG_BRAKE_FAULT_LOW]  <= '0;
      cfg_q[ppm_pkg::CFG_BRAKE_FAULT_HIGH] <= '1;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Division set-up: pedal travel past its zero point
  logic [AW-1:0] top_val, bot_val, travel, span_sel;
  logic [NW-1:0] num;

  always_comb begin
    top_val  = cmd_i.sel ? cfg_q[ppm_pkg::CFG_APPS2_MAX] : raw1_q;
    bot_val  = cmd_i.sel ? raw2_q : cfg_q[ppm_pkg::CFG_APPS1_MIN];
    span_sel = cmd_i.sel ? cfg_q[ppm_pkg::CFG_APPS2_SPAN] : cfg_q[ppm_pkg::CFG_APPS1_SPAN];
    travel   = (top_val > bot_val) ? (top_val - bot_val) : '0;
    // travel * 32767 as a shift and subtract
    num      = {travel, {SW{1'b0}}} - {{SW{1'b0}}, travel};
  end

  // One restoring division step; a zero span yields no quotient bits
  logic [AW:0] trial, trial_sub;
  logic        q_bit;

  always_comb begin
    trial     = {rem_q, lo_q[SW-1]};
    trial_sub = trial - {1'b0, span_q};
    q_bit     = (span_q != '0) && (trial >= {1'b0, span_q});
    rem_d     = q_bit ? trial_sub[AW-1:0] : trial[AW-1:0];
  end

  logic [SW-1:0] div_res;
  assign div_res = sat_q ? ppm_pkg::FULL_SCALE : quo_q;

  assign sts_o.div_last = (cnt_q == '0);

  // Capture inputs and run the shared divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw1_q  <= pedal1_adc_i;
      raw2_q  <= pedal2_adc_i;
      front_q <= front_press_adc_i;
      rear_q  <= rear_press_adc_i;
      now_q   <= now_ms_i;
    end
    if (cmd_i.load) begin
      // quotient reaches full scale once travel covers the span
      sat_q  <= (travel != '0) && (travel >= span_sel);
      span_q <= span_sel;
      rem_q  <= num[NW-1:SW];
      lo_q   <= num[SW-1:0];
      quo_q  <= '0;
      cnt_q  <= CW'(SW - 1);
      if (cmd_i.sel) s1_q <= div_res;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[SW-2:0], 1'b0};
      quo_q <= {quo_q[SW-2:0], q_bit};
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // Fault evaluation
  logic [SW-1:0] s2, diff;
  logic [DW-1:0] diff10;
  logic          dis_now, dis_fault, brk_fault, latch_d;
  logic [TW-1:0] start_eff, elapsed;

  always_comb begin
    s2        = div_res;
    diff      = (s1_q > s2) ? (s1_q - s2) : (s2 - s1_q);
    diff10    = ({4'b0000, diff} << 3) + ({4'b0000, diff} << 1);
    dis_now   = diff10 > DW'(ppm_pkg::FULL_SCALE);
    start_eff = dis_act_q ? dis_start_q : now_q;
    elapsed   = now_q - start_eff;
    dis_fault = dis_now && (elapsed >= TW'(ppm_pkg::DISAGREE_TIME_MS));
    brk_fault = (front_q > cfg_q[ppm_pkg::CFG_BRAKE_FAULT_HIGH]) ||
                (front_q < cfg_q[ppm_pkg::CFG_BRAKE_FAULT_LOW]);
    priority if ((front_q > cfg_q[ppm_pkg::CFG_FRONT_BRAKE_MIN]) &&
                 (rear_q > cfg_q[ppm_pkg::CFG_REAR_BRAKE_MIN]) &&
                 (s1_q > ppm_pkg::LATCH_SET_LEVEL)) begin
      latch_d = 1'b1;
    end else if (s1_q <= ppm_pkg::LATCH_CLEAR_LEVEL) begin
      latch_d = 1'b0;
    end else begin
      latch_d = latch_q;
    end
  end

  // Advance the fault state on each committed sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dis_act_q   <= 1'b0;
      dis_start_q <= '0;
      latch_q     <= 1'b0;
    end else if (cmd_i.commit) begin
      dis_act_q   <= dis_now;
      dis_start_q <= dis_now ? start_eff : '0;
      latch_q     <= latch_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q.apps1_scaled         <= s1_q;
      res_q.apps2_scaled         <= s2;
      res_q.brake_sensor_fault   <= brk_fault;
      res_q.apps_disagree_fault  <= dis_fault;
      res_q.brake_throttle_fault <= latch_d;
      res_q.any_fault            <= brk_fault || dis_fault || latch_d;
    end
  end

  assign res_o = res_q;

endmodule

### src/ppm_checker.sv
module ppm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ppm_pkg::SCALE_W-1:0] apps1_scaled_i,
  input logic [ppm_pkg::SCALE_W-1:0] apps2_scaled_i,
  input logic                        brake_sensor_fault_i,
  input logic                        apps_disagree_fault_i,
  input logic                        brake_throttle_fault_i,
  input logic                        any_fault_i
);

  // A pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // One sample at a time: no second transfer straight after the first
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a sample is in progress");

  // Summary flag follows the three faults
  a_any_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> any_fault_i == (brake_sensor_fault_i || apps_disagree_fault_i ||
                                    brake_throttle_fault_i))
    else $error("any_fault inconsistent");

  // Latch is released at low pedal
  a_latch_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (apps1_scaled_i <= ppm_pkg::LATCH_CLEAR_LEVEL) |-> !brake_throttle_fault_i)
    else $error("brake-throttle fault with pedal released");

  // Equal pedal positions never disagree
  a_no_disagree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (apps1_scaled_i == apps2_scaled_i) |-> !apps_disagree_fault_i)
    else $error("disagreement fault with matching pedals");

endmodule

bind pedal_plausibility_monitor ppm_checker u_ppm_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_i.valid),
  .in_ready_i             (in_i.ready),
  .out_valid_i            (out_o.valid),
  .out_ready_i            (out_o.ready),
  .apps1_scaled_i         (out_o.apps1_scaled),
  .apps2_scaled_i         (out_o.apps2_scaled),
  .brake_sensor_fault_i   (out_o.brake_sensor_fault),
  .apps_disagree_fault_i  (out_o.apps_disagree_fault),
  .brake_throttle_fault_i (out_o.brake_throttle_fault),
  .any_fault_i            (out_o.any_fault)
);

### tb/pedal_plausibility_monitor_tb.sv
`timescale 1ns / 100ps

module pedal_plausibility_monitor_tb;
  import ppm_pkg::*;

  localparam int unsigned ADC_MAX          = (1 << ADC_W) - 1;
  localparam int unsigned QUIET_LIMIT      = 5000;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned NUM_PHASES       = 9;
  localparam int unsigned ITEMS_PER_PHASE  = 83;
  localparam int unsigned MAX_GAP          = 60;

  typedef struct packed {
    logic [ADC_W-1:0]  pedal1_adc;
    logic [ADC_W-1:0]  pedal2_adc;
    logic [ADC_W-1:0]  front_press_adc;
    logic [ADC_W-1:0]  rear_press_adc;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  // Predicts one verdict per sample set and checks the block's verdicts in order
  class plausibility_scoreboard;
    logic [ADC_W-1:0]  regs [NUM_REGS];
    logic              disagree_active;
    logic [TIME_W-1:0] disagree_start;
    logic              throttle_latched;
    res_t              expected_verdicts [$];
    int unsigned       fail_count;

    function new();
      regs[CFG_APPS1_MIN]        = '0;
      regs[CFG_APPS1_SPAN]       = ADC_W'(ADC_MAX);
      regs[CFG_APPS2_MAX]        = ADC_W'(ADC_MAX);
      regs[CFG_APPS2_SPAN]       = ADC_W'(ADC_MAX);
      regs[CFG_FRONT_BRAKE_MIN]  = '0;
      regs[CFG_REAR_BRAKE_MIN]   = '0;
      regs[CFG_BRAKE_FAULT_LOW]  = '0;
      regs[CFG_BRAKE_FAULT_HIGH] = ADC_W'(ADC_MAX);
      disagree_active  = 1'b0;
      disagree_start   = '0;
      throttle_latched = 1'b0;
      fail_count       = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [ADC_W-1:0] val);
      regs[idx] = val;
    endfunction

    // Travel past the zero point, scaled to full scale; a zero span saturates
    function logic [SCALE_W-1:0] scale_travel(int unsigned travel, logic [ADC_W-1:0] span);
      int unsigned q;
      if (travel == 0) return '0;
      if (span == 0) return FULL_SCALE;
      q = (travel * FULL_SCALE) / span;
      if (q > FULL_SCALE) q = FULL_SCALE;
      return SCALE_W'(q);
    endfunction

    function void predict_verdict(sample_t smp);
      int unsigned        travel1;
      int unsigned        travel2;
      int unsigned        diff;
      logic [SCALE_W-1:0] s1;
      logic [SCALE_W-1:0] s2;
      res_t               v;
      travel1 = (smp.pedal1_adc > regs[CFG_APPS1_MIN]) ?
                32'(smp.pedal1_adc - regs[CFG_APPS1_MIN]) : 0;
      travel2 = (regs[CFG_APPS2_MAX] > smp.pedal2_adc) ?
                32'(regs[CFG_APPS2_MAX] - smp.pedal2_adc) : 0;
      s1 = scale_travel(travel1, regs[CFG_APPS1_SPAN]);
      s2 = scale_travel(travel2, regs[CFG_APPS2_SPAN]);
      v = '0;
      v.apps1_scaled = s1;
      v.apps2_scaled = s2;
      v.brake_sensor_fault = (smp.front_press_adc > regs[CFG_BRAKE_FAULT_HIGH]) ||
                             (smp.front_press_adc < regs[CFG_BRAKE_FAULT_LOW]);

      // Time the disagreement from its first sample, modulo the timestamp width
      diff = (s1 > s2) ? 32'(s1 - s2) : 32'(s2 - s1);
      if (diff * 10 > FULL_SCALE) begin
        if (!disagree_active) begin
          disagree_active = 1'b1;
          disagree_start  = smp.now_ms;
        end
        v.apps_disagree_fault = (smp.now_ms - disagree_start) >= DISAGREE_TIME_MS;
      end else begin
        disagree_active = 1'b0;
        disagree_start  = '0;
      end

      // Set on brake plus throttle, clear once the pedal is nearly released
      if (smp.front_press_adc > regs[CFG_FRONT_BRAKE_MIN] &&
          smp.rear_press_adc > regs[CFG_REAR_BRAKE_MIN] && s1 > LATCH_SET_LEVEL) begin
        throttle_latched = 1'b1;
      end else if (s1 <= LATCH_CLEAR_LEVEL) begin
        throttle_latched = 1'b0;
      end
      v.brake_throttle_fault = throttle_latched;
      v.any_fault = v.brake_sensor_fault | v.apps_disagree_fault | v.brake_throttle_fault;
      expected_verdicts.push_back(v);
    endfunction

    function void report_field(string field, int unsigned want, int unsigned got);
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      fail_count++;
    endfunction

    function void check_verdict(res_t got);
      res_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result transfer with no sample outstanding", $time);
        fail_count++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.apps1_scaled !== want.apps1_scaled)
        report_field("apps1_scaled", want.apps1_scaled, got.apps1_scaled);
      if (got.apps2_scaled !== want.apps2_scaled)
        report_field("apps2_scaled", want.apps2_scaled, got.apps2_scaled);
      if (got.brake_sensor_fault !== want.brake_sensor_fault)
        report_field("brake_sensor_fault", want.brake_sensor_fault, got.brake_sensor_fault);
      if (got.apps_disagree_fault !== want.apps_disagree_fault)
        report_field("apps_disagree_fault", want.apps_disagree_fault,
                     got.apps_disagree_fault);
      if (got.brake_throttle_fault !== want.brake_throttle_fault)
        report_field("brake_throttle_fault", want.brake_throttle_fault,
                     got.brake_throttle_fault);
      if (got.any_fault !== want.any_fault)
        report_field("any_fault", want.any_fault, got.any_fault);
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ADC_W-1:0]     cfg_data_i;

  ppm_in_if  in_if ();
  ppm_out_if out_if ();

  plausibility_scoreboard sb = new();

  int unsigned       tx_idle_pct = 27;
  int unsigned       rx_idle_pct = 84;
  int unsigned       rx_hold     = 0;
  int unsigned       quiet_cycles;
  int unsigned       episode_left;
  logic              split_mode;
  logic [TIME_W-1:0] clock_ms;

  pedal_plausibility_monitor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Check each result transfer, then predict from each sample transfer
  initial begin
    sample_t smp;
    res_t    got;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.apps1_scaled         = out_if.apps1_scaled;
        got.apps2_scaled         = out_if.apps2_scaled;
        got.brake_sensor_fault   = out_if.brake_sensor_fault;
        got.apps_disagree_fault  = out_if.apps_disagree_fault;
        got.brake_throttle_fault = out_if.brake_throttle_fault;
        got.any_fault            = out_if.any_fault;
        sb.check_verdict(got);
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        smp.pedal1_adc      = in_if.pedal1_adc;
        smp.pedal2_adc      = in_if.pedal2_adc;
        smp.front_press_adc = in_if.front_press_adc;
        smp.rear_press_adc  = in_if.rear_press_adc;
        smp.now_ms          = in_if.now_ms;
        sb.predict_verdict(smp);
      end
    end
  end

  // Abort when no transfer happens on either channel for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic sample_t mk_sample(int unsigned a1, int unsigned a2, int unsigned fb,
                                        int unsigned rb, logic [TIME_W-1:0] now);
    sample_t smp;
    smp.pedal1_adc      = ADC_W'(a1);
    smp.pedal2_adc      = ADC_W'(a2);
    smp.front_press_adc = ADC_W'(fb);
    smp.rear_press_adc  = ADC_W'(rb);
    smp.now_ms          = now;
    return smp;
  endfunction

  function automatic logic [ADC_W-1:0] clamp_adc(int x);
    if (x < 0) return '0;
    if (x > int'(ADC_MAX)) return ADC_W'(ADC_MAX);
    return ADC_W'(x);
  endfunction

  // Mostly pressed or released against the threshold, sometimes anything
  function automatic logic [ADC_W-1:0] pick_brake(logic [ADC_W-1:0] thresh);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45 && thresh != ADC_W'(ADC_MAX))
      return ADC_W'($urandom_range(ADC_MAX, 32'(thresh) + 1));
    if (roll < 90)
      return ADC_W'($urandom_range(32'(thresh)));
    return ADC_W'($urandom);
  endfunction

  function automatic logic [ADC_W-1:0] pick_span();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return ADC_W'(1);
    if (roll < 35) return ADC_W'(ADC_MAX);
    return ADC_W'($urandom_range(ADC_MAX, 200));
  endfunction

  // Pedal pairs that track each other, with episodes of disagreement
  task automatic next_random_sample(output sample_t smp);
    int unsigned f1;
    int unsigned f2;
    int unsigned roll;
    int          a1;
    int          a2;
    if (episode_left == 0) begin
      split_mode   = ($urandom_range(99) < 35);
      episode_left = $urandom_range(25, 3);
    end
    episode_left--;
    f1 = $urandom_range(ADC_MAX);
    f2 = split_mode ? $urandom_range(ADC_MAX) : f1;
    a1 = int'(sb.regs[CFG_APPS1_MIN]) + int'(f1 * sb.regs[CFG_APPS1_SPAN] / ADC_MAX) +
         int'($urandom_range(40)) - 20;
    a2 = int'(sb.regs[CFG_APPS2_MAX]) - int'(f2 * sb.regs[CFG_APPS2_SPAN] / ADC_MAX) +
         int'($urandom_range(40)) - 20;
    smp.pedal1_adc = ($urandom_range(99) < 10) ? ADC_W'($urandom) : clamp_adc(a1);
    smp.pedal2_adc = ($urandom_range(99) < 10) ? ADC_W'($urandom) : clamp_adc(a2);
    smp.front_press_adc = pick_brake(sb.regs[CFG_FRONT_BRAKE_MIN]);
    smp.rear_press_adc  = pick_brake(sb.regs[CFG_REAR_BRAKE_MIN]);

    // Advance the timestamp in small steps, sometimes larger ones, now and then jump anywhere
    roll = $urandom_range(99);
    if (roll < 85)
      clock_ms += $urandom_range(30);
    else if (roll < 95)
      clock_ms += $urandom_range(400, 100);
    else
      clock_ms = $urandom;
    smp.now_ms = clock_ms;
  endtask

  task automatic send_sample(input sample_t smp);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.pedal1_adc      <= smp.pedal1_adc;
    in_if.pedal2_adc      <= smp.pedal2_adc;
    in_if.front_press_adc <= smp.front_press_adc;
    in_if.rear_press_adc  <= smp.rear_press_adc;
    in_if.now_ms          <= smp.now_ms;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  // Stop offering samples and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ADC_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Register sets: defaults, extremes, a typical pedal, zero spans, then random
  task automatic configure(input int unsigned phase);
    logic [ADC_W-1:0] v [NUM_REGS];
    case (phase)
      0: v = '{12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd4095};
      1: v = '{12'd4095, 12'd1, 12'd0, 12'd1, 12'd4095, 12'd4095, 12'd4095, 12'd0};
      2: v = '{12'd400, 12'd3000, 12'd3700, 12'd3000, 12'd500, 12'd600, 12'd100, 12'd3900};
      3: v = '{12'd300, 12'd0, 12'd3800, 12'd0, 12'd200, 12'd200, 12'd50, 12'd4000};
      default: begin
        v[CFG_APPS1_MIN]        = ADC_W'($urandom_range(1500));
        v[CFG_APPS1_SPAN]       = pick_span();
        v[CFG_APPS2_MAX]        = ADC_W'($urandom_range(ADC_MAX, 2500));
        v[CFG_APPS2_SPAN]       = pick_span();
        v[CFG_FRONT_BRAKE_MIN]  = ADC_W'($urandom_range(3000));
        v[CFG_REAR_BRAKE_MIN]   = ADC_W'($urandom_range(3000));
        v[CFG_BRAKE_FAULT_LOW]  = ADC_W'($urandom_range(300));
        v[CFG_BRAKE_FAULT_HIGH] = ADC_W'($urandom_range(ADC_MAX, 3700));
      end
    endcase
    for (int i = 0; i < NUM_REGS; i++) write_reg(cfg_idx_e'(i), v[i]);
  endtask

  initial begin
    sample_t smp;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_APPS1_MIN;
    cfg_data_i            = '0;
    in_if.valid           = 1'b0;
    in_if.pedal1_adc      = '0;
    in_if.pedal2_adc      = '0;
    in_if.front_press_adc = '0;
    in_if.rear_press_adc  = '0;
    in_if.now_ms          = '0;
    clock_ms              = '0;
    episode_left          = 0;
    split_mode            = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed samples at reset configuration
    // Disagreement held from 0 ms: not yet at 99 ms, fault at 100 ms
    send_sample(mk_sample(0, 0, 0, 0, 32'd0));
    send_sample(mk_sample(0, 0, 4095, 4095, 32'd99));
    send_sample(mk_sample(0, 0, 4095, 0, 32'd100));
    // Full throttle with both brakes sets the latch, mid travel holds it
    send_sample(mk_sample(4095, 0, 4095, 4095, 32'd150));
    send_sample(mk_sample(2048, 2047, 0, 0, 32'd160));
    // Just above and then just below the release level
    send_sample(mk_sample(205, 3890, 0, 0, 32'd170));
    send_sample(mk_sample(204, 3891, 0, 0, 32'd180));
    // Rear brake not above its minimum, then both brakes
    send_sample(mk_sample(4095, 0, 1, 0, 32'd190));
    send_sample(mk_sample(4095, 0, 1, 1, 32'd200));
    send_sample(mk_sample(0, 4095, 0, 0, 32'd210));
    // Disagreement across the timestamp wrap
    send_sample(mk_sample(4095, 4095, 0, 0, 32'hFFFF_FFF0));
    send_sample(mk_sample(4095, 4095, 0, 0, 32'hFFFF_FFFF));
    send_sample(mk_sample(4095, 4095, 0, 0, 32'h0000_0053));
    send_sample(mk_sample(4095, 4095, 0, 0, 32'h0000_0054));
    // Alternating bit patterns and all ones
    send_sample(mk_sample(12'hAAA, 12'h555, 12'hAAA, 12'h555, 32'hAAAA_AAAA));
    send_sample(mk_sample(12'h555, 12'hAAA, 12'h555, 12'hAAA, 32'h5555_5555));
    send_sample(mk_sample(4095, 4095, 4095, 4095, 32'hFFFF_FFFF));

    // Random phases, three per idling profile
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase / 3)
        0: begin tx_idle_pct = 27; rx_idle_pct = 84; end
        1: begin tx_idle_pct = 84; rx_idle_pct = 27; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      configure(phase);
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Starve the output while samples keep coming, so the input stalls
        if (phase == 1 && i == 30) rx_hold = LONG_HOLD_CYCLES;
        // Let the block run empty mid-phase
        if (phase == 4 && i == 40) drain_results();
        next_random_sample(smp);
        send_sample(smp);
      end
    end

    drain_results();
    if (sb.fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
